// ===== rtl/core/tmle_pkg.sv =====
package tmle_pkg;

    // Command codes
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_RENDER = 2'd2;

    // Register window addresses
    localparam logic [1:0] ADDR_COL  = 2'd0;
    localparam logic [1:0] ADDR_ROW  = 2'd1;
    localparam logic [1:0] ADDR_CELL = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_MAP_COLS = 3'd1;
    localparam logic [2:0] CFG_MAP_ROWS = 3'd2;
    localparam logic [2:0] CFG_TILE_W   = 3'd3;
    localparam logic [2:0] CFG_TILE_H   = 3'd4;
    localparam logic [2:0] CFG_SCR_W    = 3'd5;
    localparam logic [2:0] CFG_SCR_H    = 3'd6;
    localparam logic [2:0] CFG_SRC_W    = 3'd7;

    // Configuration reset values
    localparam logic [7:0] MAP_COLS_RST = 8'd1;
    localparam logic [7:0] MAP_ROWS_RST = 8'd1;
    localparam logic [6:0] TILE_W_RST   = 7'd8;
    localparam logic [6:0] TILE_H_RST   = 7'd8;
    localparam logic [8:0] SCR_W_RST    = 9'd128;
    localparam logic [8:0] SCR_H_RST    = 9'd128;
    localparam logic [8:0] SRC_W_RST    = 9'd128;

    // Cell store
    localparam int CELL_DEPTH_DEF = 4096;
    localparam int CELL_IDX_W     = 16;

    // Shared restoring divider: 9-bit operands, one quotient bit a cycle
    localparam int DIV_W     = 9;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'(DIV_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP_OFS,
        S_SETUP_DIV,
        S_CELL_RD,
        S_DIV_COL,
        S_DIV_ROW,
        S_MAP,
        S_TILE,
        S_DIV_TILE,
        S_SRC
    } tmle_state_t;

endpackage

// ===== rtl/core/tmle_ram.sv =====
module tmle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tile_map_layer_engine.sv =====
// Tile map layer: register window (cursor moves, cell writes and reads) and a
// per-pixel renderer that returns the screen index and tile source index of a
// layer-local pixel. An item is taken when start is high and busy is low; its
// single result appears on the result ports for one cycle with done high, and
// must be taken then, as there is no way to hold it off. Any write, cursor
// read, disabled or unknown command, or render with a zero tile size is
// answered from S_IDLE; a cell read goes through S_CELL_RD for the registered
// memory read. A render takes passes through the shared one-bit-per-cycle
// divider for column and row, reads the map cell (S_MAP, S_TILE) and, for a
// drawn pixel, takes a third pass for the tile position in the source image.
// busy stays high until the block can take the next item. After reset and
// after any write to layer_enabled, the cell memory is cleared one entry a
// cycle, which keeps busy high until every entry is cleared. Every config beat
// also holds busy while the centering offsets and tiles per source row are
// recomputed. Configuration beats are always taken (cfg_ready is tied high).
module tile_map_layer_engine
    import tmle_pkg::*;
#(
    parameter int CELL_DEPTH = CELL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [1:0]  reg_addr,
    input  logic [7:0]  write_value,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    // result
    output logic        done,
    output logic [7:0]  read_data,
    output logic        draw,
    output logic [15:0] dest_index,
    output logic [15:0] source_index,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int ADDR_W = $clog2(CELL_DEPTH);
    localparam logic [CELL_IDX_W:0] DEPTH_LIM = (CELL_IDX_W+1)'(CELL_DEPTH);
    localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(CELL_DEPTH - 1);

    tmle_state_t state_reg, state_next;

    // configuration
    logic       enabled_reg;
    logic [7:0] map_cols_reg, map_rows_reg;
    logic [6:0] tile_w_reg, tile_h_reg;
    logic [8:0] scr_w_reg, scr_h_reg, src_w_reg;

    // cursors
    logic [7:0] cur_col_reg, cur_row_reg;

    // memory clearing pass
    logic              clearing_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;

    // derived from configuration
    logic [8:0] per_row_reg;
    logic [7:0] ox_reg, oy_reg;

    // render datapath
    logic [7:0]  px_reg, py_reg;
    logic [7:0]  col_reg, row_reg;
    logic [6:0]  pxr_reg, pyr_reg;
    logic        ok_reg;
    logic [15:0] dest_reg;
    logic [14:0] srcx_reg, srcy_reg;

    // divider
    logic [DIV_W-1:0]     div_rem_reg, div_quo_reg, div_den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_W:0]       div_shift, div_diff;
    logic                 div_ge, div_done;
    logic                 div_load;
    logic [DIV_W-1:0]     div_num, div_den;

    // result
    logic        done_reg, draw_reg;
    logic [7:0]  read_data_reg;
    logic [15:0] dest_idx_reg, src_idx_reg;
    logic        res_valid, res_draw;
    logic [7:0]  res_rd;
    logic [15:0] res_dest, res_src;

    // misc control
    logic accept, cfg_we;
    logic col_we, row_we, cell_we;

    // memory ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    // address and index arithmetic
    logic [CELL_IDX_W-1:0] k_cur, k_map;
    logic                  k_cur_ok, k_map_ok;
    logic [14:0] span_x, span_y;
    logic [8:0]  diff_x, diff_y;
    logic [7:0]  ox_calc, oy_calc;
    logic [8:0]  sx, sy;
    logic [17:0] dest_full;
    logic [14:0] srcx_calc, srcy_calc;
    logic [23:0] src_full;
    logic        map_ok;
    logic [7:0]  tile_m1;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign busy      = (state_reg != S_IDLE) || clearing_reg;

    // Cell under the cursor and cell under the rendered pixel
    assign k_cur    = 16'(cur_row_reg) * 16'(map_cols_reg) + 16'(cur_col_reg);
    assign k_map    = 16'(row_reg) * 16'(map_cols_reg) + 16'(col_reg);
    assign k_cur_ok = {1'b0, k_cur} < DEPTH_LIM;
    assign k_map_ok = {1'b0, k_map} < DEPTH_LIM;

    // Centering offsets, saturating at zero when the layer overhangs
    assign span_x  = 15'(map_cols_reg) * 15'(tile_w_reg);
    assign span_y  = 15'(map_rows_reg) * 15'(tile_h_reg);
    assign diff_x  = scr_w_reg - span_x[8:0];
    assign diff_y  = scr_h_reg - span_y[8:0];
    assign ox_calc = (span_x >= 15'(scr_w_reg)) ? 8'd0 : diff_x[8:1];
    assign oy_calc = (span_y >= 15'(scr_h_reg)) ? 8'd0 : diff_y[8:1];

    // Screen position and index
    assign sx        = 9'(ox_reg) + 9'(px_reg);
    assign sy        = 9'(oy_reg) + 9'(py_reg);
    assign dest_full = 18'(sy) * 18'(scr_w_reg) + 18'(sx);
    assign map_ok    = (col_reg < map_cols_reg) && (row_reg < map_rows_reg)
                       && (per_row_reg != 9'd0) && (sx < scr_w_reg)
                       && (sy < scr_h_reg) && k_map_ok;

    // Source position from tile slot (remainder, quotient) and in-tile offset
    assign srcx_calc = 15'(div_rem_reg) * 15'(tile_w_reg) + 15'(pxr_reg);
    assign srcy_calc = 15'(div_quo_reg) * 15'(tile_h_reg) + 15'(pyr_reg);
    assign src_full  = 24'(srcy_reg) * 24'(src_w_reg) + 24'(srcx_reg);
    assign tile_m1   = ram_rdata - 8'd1;

    // Divider step
    assign div_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign div_ge    = div_shift >= {1'b0, div_den_reg};
    assign div_done  = (div_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_num;
            div_den_reg <= div_den;
            div_cnt_reg <= DIV_STEPS;
        end
        else if (!div_done)
        begin
            div_rem_reg <= div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SETUP_OFS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        div_load   = 1'b0;
        div_num    = '0;
        div_den    = '0;
        res_valid  = 1'b0;
        res_rd     = 8'd0;
        res_draw   = 1'b0;
        res_dest   = 16'd0;
        res_src    = 16'd0;
        col_we     = 1'b0;
        row_we     = 1'b0;
        cell_we    = 1'b0;

        case (state_reg)
            S_SETUP_OFS:
            begin
                div_load   = 1'b1;
                div_num    = src_w_reg;
                div_den    = 9'(tile_w_reg);
                state_next = S_SETUP_DIV;
            end
            S_SETUP_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_WRITE:
                        begin
                            res_valid = 1'b1;
                            if (enabled_reg)
                            begin
                                case (reg_addr)
                                    ADDR_COL:  col_we  = write_value < map_cols_reg;
                                    ADDR_ROW:  row_we  = write_value < map_rows_reg;
                                    ADDR_CELL: cell_we = k_cur_ok;
                                    default:   cell_we = 1'b0;
                                endcase
                            end
                        end
                        CMD_READ:
                        begin
                            if (enabled_reg && (reg_addr == ADDR_CELL) && k_cur_ok)
                            begin
                                state_next = S_CELL_RD;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                                if (enabled_reg)
                                begin
                                    case (reg_addr)
                                        ADDR_COL: res_rd = cur_col_reg;
                                        ADDR_ROW: res_rd = cur_row_reg;
                                        default:  res_rd = 8'd0;
                                    endcase
                                end
                            end
                        end
                        CMD_RENDER:
                        begin
                            if (enabled_reg && (tile_w_reg != 7'd0) && (tile_h_reg != 7'd0))
                            begin
                                div_load   = 1'b1;
                                div_num    = 9'(pixel_x);
                                div_den    = 9'(tile_w_reg);
                                state_next = S_DIV_COL;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_CELL_RD:
            begin
                res_valid  = 1'b1;
                res_rd     = ram_rdata;
                state_next = S_IDLE;
            end
            S_DIV_COL:
            begin
                if (div_done)
                begin
                    div_load   = 1'b1;
                    div_num    = 9'(py_reg);
                    div_den    = 9'(tile_h_reg);
                    state_next = S_DIV_ROW;
                end
            end
            S_DIV_ROW:
            begin
                if (div_done)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_TILE;
            end
            S_TILE:
            begin
                // tile zero is transparent
                if (ok_reg && (ram_rdata != 8'd0))
                begin
                    div_load   = 1'b1;
                    div_num    = 9'(tile_m1);
                    div_den    = per_row_reg;
                    state_next = S_DIV_TILE;
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV_TILE:
            begin
                if (div_done)
                begin
                    state_next = S_SRC;
                end
            end
            S_SRC:
            begin
                res_valid  = 1'b1;
                res_draw   = 1'b1;
                res_dest   = dest_reg;
                res_src    = src_full[15:0];
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any configuration beat reruns the set-up arithmetic
        if (cfg_we)
        begin
            state_next = S_SETUP_OFS;
        end
    end

    // Configuration registers and cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            map_cols_reg <= MAP_COLS_RST;
            map_rows_reg <= MAP_ROWS_RST;
            tile_w_reg   <= TILE_W_RST;
            tile_h_reg   <= TILE_H_RST;
            scr_w_reg    <= SCR_W_RST;
            scr_h_reg    <= SCR_H_RST;
            src_w_reg    <= SRC_W_RST;
            cur_col_reg  <= 8'd0;
            cur_row_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:   enabled_reg  <= cfg_data[0];
                    CFG_MAP_COLS: map_cols_reg <= cfg_data[7:0];
                    CFG_MAP_ROWS: map_rows_reg <= cfg_data[7:0];
                    CFG_TILE_W:   tile_w_reg   <= cfg_data[6:0];
                    CFG_TILE_H:   tile_h_reg   <= cfg_data[6:0];
                    CFG_SCR_W:    scr_w_reg    <= cfg_data;
                    CFG_SCR_H:    scr_h_reg    <= cfg_data;
                    CFG_SRC_W:    src_w_reg    <= cfg_data;
                    default:      enabled_reg  <= enabled_reg;
                endcase
            end
            // a write to the enable register homes both cursors
            if (cfg_we && (cfg_index == CFG_ENABLE))
            begin
                cur_col_reg <= 8'd0;
                cur_row_reg <= 8'd0;
            end
            else
            begin
                if (col_we)
                begin
                    cur_col_reg <= write_value;
                end
                if (row_we)
                begin
                    cur_row_reg <= write_value;
                end
            end
        end
    end

    // Clearing pass over the cell memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (cfg_we && (cfg_index == CFG_ENABLE))
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_cnt_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SETUP_OFS)
        begin
            ox_reg <= ox_calc;
            oy_reg <= oy_calc;
        end
        if ((state_reg == S_SETUP_DIV) && div_done)
        begin
            per_row_reg <= div_quo_reg;
        end
        if (accept)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if ((state_reg == S_DIV_COL) && div_done)
        begin
            col_reg <= div_quo_reg[7:0];
            pxr_reg <= div_rem_reg[6:0];
        end
        if ((state_reg == S_DIV_ROW) && div_done)
        begin
            row_reg <= div_quo_reg[7:0];
            pyr_reg <= div_rem_reg[6:0];
        end
        if (state_reg == S_MAP)
        begin
            ok_reg   <= map_ok;
            dest_reg <= dest_full[15:0];
        end
        if ((state_reg == S_DIV_TILE) && div_done)
        begin
            srcx_reg <= srcx_calc;
            srcy_reg <= srcy_calc;
        end
    end

    // Result registers: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            read_data_reg <= res_rd;
            draw_reg      <= res_draw;
            dest_idx_reg  <= res_dest;
            src_idx_reg   <= res_src;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign draw         = draw_reg;
    assign dest_index   = dest_idx_reg;
    assign source_index = src_idx_reg;

    // Cell memory: clearing pass or cell write; read at cursor or map cell
    assign ram_we    = clearing_reg || cell_we;
    assign ram_waddr = clearing_reg ? clear_cnt_reg : k_cur[ADDR_W-1:0];
    assign ram_wdata = clearing_reg ? 8'd0 : write_value;
    assign ram_raddr = (state_reg == S_MAP) ? k_map[ADDR_W-1:0] : k_cur[ADDR_W-1:0];

    tmle_ram #(
        .WIDTH (8),
        .DEPTH (CELL_DEPTH)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
